FILE: rtl/mste_pkg.sv
// ----------------------------------------------------------------------------
// mste_pkg
// Shared sizes, types and helpers of the max segment tree engine.
// ----------------------------------------------------------------------------
package mste_pkg;

    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = 10;
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_BITS  = $clog2(NODES);
    // Query bounds are half open, so the right bound can reach NODES itself.
    localparam int POS_BITS   = NODE_BITS + 1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [POS_BITS-1:0]   t_pos;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_LEAF,
        ST_UPD_NODE,
        ST_Q_INIT,
        ST_Q_STEP,
        ST_Q_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr;
        logic upd_rd;
        logic upd_leaf;
        logic upd_node;
        logic q_init;
        logic q_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic at_top;
        logic loop_done;
        logic out_free;
    } t_dp_stat;

    function automatic t_value max_of(input t_value a, input t_value b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: rtl/mste_ctrl.sv
// ----------------------------------------------------------------------------
// mste_ctrl
// Sequencer of the engine: memory clear, update walk and query walk.
// ----------------------------------------------------------------------------
module mste_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    input  mste_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output mste_pkg::t_dp_cmd  o_dp_cmd
);
    import mste_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                // A 10-bit leaf index always lies inside the table.
                if (i_in_valid) begin
                    n_state = (i_in_cmd == CMD_QUERY) ? ST_Q_INIT : ST_UPD_RD;
                end
            end
            ST_UPD_RD:   n_state = ST_UPD_LEAF;
            ST_UPD_LEAF: n_state = ST_UPD_NODE;
            ST_UPD_NODE: begin
                if (i_stat.at_top) n_state = ST_IDLE;
            end
            ST_Q_INIT:   n_state = ST_Q_STEP;
            ST_Q_STEP: begin
                if (i_stat.loop_done) n_state = ST_Q_DONE;
            end
            ST_Q_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_dp_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR:    o_dp_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_dp_cmd.load = i_in_valid;
            end
            ST_UPD_RD:   o_dp_cmd.upd_rd   = 1'b1;
            ST_UPD_LEAF: o_dp_cmd.upd_leaf = 1'b1;
            ST_UPD_NODE: o_dp_cmd.upd_node = 1'b1;
            ST_Q_INIT:   o_dp_cmd.q_init   = 1'b1;
            ST_Q_STEP:   o_dp_cmd.q_step   = 1'b1;
            ST_Q_DONE:   o_dp_cmd.out_load = i_stat.out_free;
            default:     o_dp_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/mste_datapath.sv
// ----------------------------------------------------------------------------
// mste_datapath
// Tree memory, walk registers, maximum units and the result register.
// ----------------------------------------------------------------------------
module mste_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mste_pkg::t_dp_cmd   i_dp_cmd,
    input  mste_pkg::t_idx      i_leaf_index,
    input  mste_pkg::t_value    i_new_value,
    input  mste_pkg::t_idx      i_range_low,
    input  mste_pkg::t_idx      i_range_high,
    input  logic                i_out_ready,
    output mste_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output mste_pkg::t_value    o_range_max
);
    import mste_pkg::*;

    // Node 1 is the root, node LEAVES + i holds leaf i, node 0 is unused.
    t_value mem [NODES];

    t_idx   r_idx;
    t_value r_val;
    t_idx   r_lo;
    t_idx   r_hi;
    t_node  r_k;
    t_value r_cur;
    t_pos   r_l;
    t_pos   r_r;
    t_value r_best;
    t_value r_rd_a;
    t_value r_rd_b;
    logic   r_use_a;
    logic   r_use_b;
    t_node  r_clr;
    logic   r_out_valid;
    t_value r_out_data;

    logic   we;
    t_node  waddr;
    t_value wdata;
    t_node  raddr_a;
    t_node  raddr_b;
    logic   n_use_a;
    logic   n_use_b;
    t_value merged;
    t_node  leaf_node;
    t_node  parent;
    t_pos   lo_pos;
    t_pos   hi_clip;
    logic   q_ok;
    t_value got_a;
    t_value got_b;

    assign leaf_node = t_node'(LEAVES) + t_node'(r_idx);
    assign parent    = r_k >> 1;
    assign lo_pos    = t_pos'(r_lo);
    assign hi_clip   = (t_pos'(r_hi) >= t_pos'(LEAVES)) ? t_pos'(LEAVES - 1) : t_pos'(r_hi);
    assign q_ok      = (lo_pos < t_pos'(LEAVES)) && (lo_pos <= hi_clip);
    assign got_a     = r_use_a ? r_rd_a : '0;
    assign got_b     = r_use_b ? r_rd_b : '0;

    always_comb begin
        we      = 1'b0;
        waddr   = r_clr;
        wdata   = '0;
        raddr_a = '0;
        raddr_b = '0;
        n_use_a = 1'b0;
        n_use_b = 1'b0;
        merged  = max_of(r_cur, r_rd_a);
        if (i_dp_cmd.clr) begin
            we = 1'b1;
        end
        if (i_dp_cmd.upd_rd) begin
            raddr_a = leaf_node;
        end
        if (i_dp_cmd.upd_leaf) begin
            merged  = max_of(r_rd_a, r_val);
            we      = 1'b1;
            waddr   = r_k;
            wdata   = merged;
            raddr_a = r_k ^ t_node'(1);
        end
        if (i_dp_cmd.upd_node) begin
            // The sibling read in the previous cycle meets the child just written.
            we      = 1'b1;
            waddr   = parent;
            wdata   = merged;
            raddr_a = parent ^ t_node'(1);
        end
        if (i_dp_cmd.q_step && (r_l < r_r)) begin
            if (r_l[0]) begin
                raddr_a = r_l[NODE_BITS-1:0];
                n_use_a = 1'b1;
            end
            if (r_r[0]) begin
                raddr_b = t_node'(r_r - t_pos'(1));
                n_use_b = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_a <= mem[raddr_a];
        r_rd_b <= mem[raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_use_a     <= 1'b0;
            r_use_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_cmd.clr) begin
                r_clr <= r_clr + t_node'(1);
            end
            r_use_a <= n_use_a;
            r_use_b <= n_use_b;
            if (i_dp_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_idx <= i_leaf_index;
            r_val <= i_new_value;
            r_lo  <= i_range_low;
            r_hi  <= i_range_high;
        end
        if (i_dp_cmd.upd_rd) begin
            r_k <= leaf_node;
        end
        if (i_dp_cmd.upd_leaf) begin
            r_cur <= merged;
        end
        if (i_dp_cmd.upd_node) begin
            r_cur <= merged;
            r_k   <= parent;
        end
        if (i_dp_cmd.q_init) begin
            r_best <= '0;
            if (q_ok) begin
                r_l <= t_pos'(LEAVES) + lo_pos;
                r_r <= t_pos'(LEAVES) + hi_clip + t_pos'(1);
            end else begin
                r_l <= '0;
                r_r <= '0;
            end
        end else begin
            r_best <= max_of(r_best, max_of(got_a, got_b));
        end
        if (i_dp_cmd.q_step && (r_l < r_r)) begin
            r_l <= (r_l + t_pos'(r_l[0])) >> 1;
            r_r <= (r_r - t_pos'(r_r[0])) >> 1;
        end
        if (i_dp_cmd.out_load) begin
            r_out_data <= r_best;
        end
    end

    assign o_stat.clr_last  = (r_clr == t_node'(NODES - 1));
    assign o_stat.at_top    = (parent == t_node'(1));
    assign o_stat.loop_done = (r_l >= r_r);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_range_max      = r_out_data;

endmodule

FILE: rtl/max_segment_tree_engine_unit.sv
// ----------------------------------------------------------------------------
// max_segment_tree_engine_unit
// Max segment tree over 1024 leaves: point raise by maximum, range query.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_ready) takes one transaction per item. With
// i_cmd at 0 the item raises leaf i_leaf_index to the maximum of its value
// and i_new_value and gives no result. With i_cmd at 1 it returns, on the
// output channel (o_valid / i_ready), the maximum over leaves i_range_low to
// i_range_high inclusive, or 0 for an empty range.
// An update walks from the leaf up to the root: a leaf read,
// the leaf write and one parent write per level, the sibling read of the next
// level overlapping with each write on the single write port of the tree.
// A query takes one step per tree level while the two bounds converge, both
// boundary nodes read in the same cycle on two read ports.
// After reset the tree memory is swept to zero, one node per cycle, with
// o_ready low. A finished result waits in the output register;
// a new item is accepted meanwhile, and a later query holds its result back
// until the waiting one is taken.
// ----------------------------------------------------------------------------
module max_segment_tree_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  mste_pkg::t_idx    i_leaf_index,
    input  mste_pkg::t_value  i_new_value,
    input  mste_pkg::t_idx    i_range_low,
    input  mste_pkg::t_idx    i_range_high,
    output logic              o_valid,
    input  logic              i_ready,
    output mste_pkg::t_value  o_range_max
);
    import mste_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_cmd   (i_cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_ready),
        .o_dp_cmd   (dp_cmd)
    );

    mste_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_leaf_index (i_leaf_index),
        .i_new_value  (i_new_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_out_ready  (i_ready),
        .o_stat       (dp_stat),
        .o_out_valid  (o_valid),
        .o_range_max  (o_range_max)
    );

    // The sequencer drives at most one datapath operation per cycle.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("more than one datapath operation in a cycle");

    // No item is taken while the tree memory is being cleared.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.clr |-> !o_ready)
        else $error("input ready during the memory clear");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_valid || i_ready))
        else $error("result register loaded while a result is pending");

    // An update transaction starts its walk and never produces a result next.
    a_update_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_cmd == CMD_UPDATE)) |=>
            (dp_cmd.upd_rd && !dp_cmd.out_load))
        else $error("update transaction did not start its tree walk");

endmodule
